>>> sv/rde_pkg.sv
// rde_pkg: shared types and constants for the run-length digit-pair encoder
// no dependencies; every other file of the block imports it

package rde_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 4;
  localparam int unsigned DigitW  = 6;

  // longest run that one pair can describe
  localparam logic [CountW-1:0] RunCap = CountW'(9);

  // ascii '0', masked to the digit field
  localparam logic [DigitW-1:0] DigitBase = DigitW'(48);

  // default depth of the pair queue, at least 2
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [DigitW-1:0] count_digit;
    logic [ByteW-1:0]  run_byte;
    logic              last_pair;
  } rde_pair_t;

  // up to two pairs written into the queue in one cycle
  typedef struct packed {
    logic      first_vld;
    rde_pair_t first;
    logic      second_vld;
    rde_pair_t second;
  } rde_push_t;

  function automatic rde_pair_t make_pair(input logic [CountW-1:0] count,
                                          input logic [ByteW-1:0]  run_byte,
                                          input logic              last);
    rde_pair_t p;
    p.count_digit = DigitBase + DigitW'(count);
    p.run_byte    = run_byte;
    p.last_pair   = last;
    return p;
  endfunction

endpackage

>>> sv/rde_chan_ifs.sv
// rde_in_if and rde_out_if: valid/ready channels of the encoder
// depends on rde_pkg for the field widths

interface rde_in_if;
  import rde_pkg::*;

  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  in_byte;
  logic              end_of_string;

  modport source (output valid, in_byte, end_of_string, input ready);
  modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

interface rde_out_if;
  import rde_pkg::*;

  logic              valid;
  logic              ready;
  logic [DigitW-1:0] count_digit;
  logic [ByteW-1:0]  run_byte;
  logic              last_pair;

  modport source (output valid, count_digit, run_byte, last_pair, input ready);
  modport sink   (input valid, count_digit, run_byte, last_pair, output ready);
endinterface

>>> sv/rde_run_tracker.sv
// rde_run_tracker: input register, open-run state and pair generation
// depends on rde_pkg and rde_in_if

module rde_run_tracker (
  input  logic              clk,
  input  logic              rst_n,
  rde_in_if.sink            in_chan,
  input  logic              queue_room,
  output rde_pkg::rde_push_t push
);
  import rde_pkg::*;

  logic              in_vld_r;
  logic [ByteW-1:0]  in_byte_r;
  logic              in_eos_r;

  logic [ByteW-1:0]  held_byte_r, held_byte_nxt;
  logic [CountW-1:0] held_count_r, held_count_nxt;
  logic              run_open_r, run_open_nxt;

  logic              consume;
  logic              close_prev;
  logic [CountW-1:0] cur_count;
  rde_pair_t         prev_pair, cur_pair;

  assign consume       = in_vld_r && queue_room;
  assign in_chan.ready = !in_vld_r || queue_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.in_byte;
      in_eos_r  <= in_chan.end_of_string;
    end
  end

  // run closes on a new byte or when one more repeat would pass the cap
  always_comb begin
    close_prev = run_open_r &&
                 !((in_byte_r == held_byte_r) && (held_count_r < RunCap));
    cur_count  = (run_open_r && !close_prev) ? held_count_r + CountW'(1)
                                             : CountW'(1);
    prev_pair  = make_pair(held_count_r, held_byte_r, 1'b0);
    cur_pair   = make_pair(cur_count, in_byte_r, 1'b1);

    push.first_vld  = consume && (close_prev || in_eos_r);
    push.first      = close_prev ? prev_pair : cur_pair;
    push.second_vld = consume && close_prev && in_eos_r;
    push.second     = cur_pair;

    if (in_eos_r) begin
      held_byte_nxt  = '0;
      held_count_nxt = '0;
      run_open_nxt   = 1'b0;
    end else begin
      held_byte_nxt  = in_byte_r;
      held_count_nxt = cur_count;
      run_open_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r  <= '0;
      held_count_r <= '0;
      run_open_r   <= 1'b0;
    end else if (consume) begin
      held_byte_r  <= held_byte_nxt;
      held_count_r <= held_count_nxt;
      run_open_r   <= run_open_nxt;
    end
  end

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.second_vld |-> (push.first_vld && !push.first.last_pair && push.second.last_pair))
    else $error("second pair without a closing first pair");

  a_eos_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && in_eos_r) |=> (!run_open_r && (held_count_r == '0)))
    else $error("run still open after end of string");

  a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (held_count_r <= RunCap) && (run_open_r == (held_count_r != '0)))
    else $error("held run length out of range");

endmodule

>>> sv/rde_pair_queue.sv
// rde_pair_queue: small register queue of finished pairs, up to two writes a cycle
// depends on rde_pkg and rde_out_if

module rde_pair_queue #(
  parameter int unsigned DEPTH = rde_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rde_pkg::rde_push_t push,
  output logic               room,
  rde_out_if.source          out_chan
);
  import rde_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rde_pair_t         mem_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              pop;
  logic [1:0]        push_n;
  logic [PtrW-1:0]   wr_ptr_inc;
  rde_pair_t         head;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign room       = (count_r <= CntW'(DEPTH - 2));
  assign pop        = out_chan.valid && out_chan.ready;
  assign push_n     = {1'b0, push.first_vld} + {1'b0, push.second_vld};
  assign wr_ptr_inc = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.second_vld) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_inc);
    end else if (push.first_vld) begin
      wr_ptr_nxt = wr_ptr_inc;
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CntW'(push_n) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first_vld) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.second_vld) begin
      mem_r[wr_ptr_inc] <= push.second;
    end
  end

  assign head                 = mem_r[rd_ptr_r];
  assign out_chan.valid       = (count_r != '0);
  assign out_chan.count_digit = head.count_digit;
  assign out_chan.run_byte    = head.run_byte;
  assign out_chan.last_pair   = head.last_pair;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.first_vld |-> (count_r <= CntW'(DEPTH - 2)))
    else $error("pair written into a full queue");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CntW'(DEPTH)) && ((count_r == '0) == (wr_ptr_r == rd_ptr_r) ||
     (count_r == CntW'(DEPTH))))
    else $error("queue fill level disagrees with pointers");

  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=> (out_chan.valid && $stable(head)))
    else $error("waiting pair changed before it was taken");

endmodule

>>> sv/rle_digit_pair_encoder_top.sv
// rle_digit_pair_encoder_top: run-length encoder emitting (digit, byte) pairs
// depends on rde_pkg, rde_chan_ifs, rde_run_tracker and rde_pair_queue
//
//  channel   | dir | transaction                            | handshake
//  ----------+-----+----------------------------------------+-----------------------
//  in_chan   | in  | one byte plus end_of_string flag       | valid/ready, sink
//  out_chan  | out | one pair: count_digit, run_byte, last  | valid/ready, source
//
// one byte is taken every cycle while the pair queue has two free slots
// a byte that closes a run and ends the string yields two pairs, which leave
//   one at a time; the queue of QUEUE_DEPTH pairs absorbs them
// a closed run's pair goes from the input register through the pair queue to out_chan
// rst_n is synchronous, active low; it empties the queue and closes any run
// a stall on out_chan fills the queue, then holds in_chan.ready low

module rle_digit_pair_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = rde_pkg::QueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  rde_in_if.sink    in_chan,
  rde_out_if.source out_chan
);
  import rde_pkg::*;

  // pairs from the run tracker into the queue
  rde_push_t push;
  // queue can take two more pairs next edge
  logic      queue_room;

  // input register, run state and pair forming
  rde_run_tracker u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .queue_room (queue_room),
    .push       (push)
  );

  // result registers, decoupling the output stall from the input side
  rde_pair_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (queue_room),
    .out_chan (out_chan)
  );

endmodule

>>> sim/tb.sv
// tb: self-checking bench for rle_digit_pair_encoder_top
// needs rde_pkg, rde_chan_ifs and the encoder rtl; the run-length predictor is built in
// a directed table comes first, then random strings with idles on both channels

`timescale 1ns / 1ps

module tb;
  import rde_pkg::*;

  // one row of the directed table; n < 0 leaves the row to the predictor alone
  typedef struct {
    logic [ByteW-1:0] data;
    logic             eos;
    int               n;
    rde_pair_t        p0;
    rde_pair_t        p1;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rde_in_if  in_if ();
  rde_out_if out_if ();

  rle_digit_pair_encoder_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // predictor state: the run currently being counted
  logic [ByteW-1:0]  run_byte_q;
  logic [CountW-1:0] run_len_q;
  logic              run_live_q;

  // pairs predicted but not yet seen on the output channel, oldest first
  rde_pair_t expected_pairs [$];
  stim_row_t directed_rows [$];

  int mismatches = 0;
  int items_sent = 0;
  bit no_idle = 1'b0;

  // typed expectation of the byte on the input channel, set alongside its payload
  int        want_n = -1;
  rde_pair_t want_p0 = '0;
  rde_pair_t want_p1 = '0;

  always #4 clk = ~clk;

  function automatic rde_pair_t pair_of(logic [DigitW-1:0] digit, logic [ByteW-1:0] b,
                                        logic last);
    rde_pair_t p;
    p.count_digit = digit;
    p.run_byte    = b;
    p.last_pair   = last;
    return p;
  endfunction

  function automatic void note_error(string msg);
    if (mismatches < 10) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatches++;
  endfunction

  // advance the run tracker by one byte; returns how many pairs it closed
  function automatic int encode_byte(logic [ByteW-1:0] b, logic eos);
    int n;
    n = 0;
    if (run_live_q && b == run_byte_q && run_len_q < RunCap) begin
      run_len_q = run_len_q + 1'b1;
    end else begin
      // a different byte, or the run is already at the cap: close it
      if (run_live_q) begin
        expected_pairs.push_back(pair_of(DigitBase + DigitW'(run_len_q), run_byte_q, 1'b0));
        n++;
      end
      run_byte_q = b;
      run_len_q  = CountW'(1);
      run_live_q = 1'b1;
    end
    if (eos) begin
      // end of string flushes the open run and starts afresh
      expected_pairs.push_back(pair_of(DigitBase + DigitW'(run_len_q), run_byte_q, 1'b1));
      n++;
      run_byte_q = '0;
      run_len_q  = '0;
      run_live_q = 1'b0;
    end
    return n;
  endfunction

  // monitor: predict on every input transaction, check every output transaction
  always @(posedge clk) begin
    int n;
    rde_pair_t got, want;
    if (rst_n && in_if.valid && in_if.ready) begin
      n = encode_byte(in_if.in_byte, in_if.end_of_string);
      if (want_n >= 0) begin
        // directed row: the predictor must agree with the typed-in pairs
        if (n != want_n) begin
          note_error($sformatf("byte %02h: predicted %0d pairs, table says %0d",
                               in_if.in_byte, n, want_n));
        end else begin
          for (int k = 0; k < n; k++) begin
            want = (k == 0) ? want_p0 : want_p1;
            got  = expected_pairs[expected_pairs.size() - n + k];
            if (got != want) begin
              note_error($sformatf("byte %02h: predicted %0d/%02h/%0d, table says %0d/%02h/%0d",
                                   in_if.in_byte, got.count_digit, got.run_byte,
                                   got.last_pair, want.count_digit, want.run_byte,
                                   want.last_pair));
            end
          end
        end
      end
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_pairs.size() == 0) begin
        note_error($sformatf("unexpected pair %0d/%02h/%0d", out_if.count_digit,
                             out_if.run_byte, out_if.last_pair));
      end else begin
        want = expected_pairs.pop_front();
        if (out_if.count_digit != want.count_digit || out_if.run_byte != want.run_byte ||
            out_if.last_pair != want.last_pair) begin
          note_error($sformatf("pair mismatch: expected %0d/%02h/%0d, got %0d/%02h/%0d",
                               want.count_digit, want.run_byte, want.last_pair,
                               out_if.count_digit, out_if.run_byte, out_if.last_pair));
        end
      end
    end
  end

  // one input transaction: random idle, then hold valid until the block takes it
  task automatic send_item(logic [ByteW-1:0] b, logic eos, int n, rde_pair_t p0,
                           rde_pair_t p1);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid         = 1'b1;
    in_if.in_byte       = b;
    in_if.end_of_string = eos;
    want_n  = n;
    want_p0 = p0;
    want_p1 = p1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic add_row(logic [ByteW-1:0] b, logic eos, int n, rde_pair_t p0,
                         rde_pair_t p1);
    stim_row_t r;
    r.data = b;
    r.eos  = eos;
    r.n    = n;
    r.p0   = p0;
    r.p1   = p1;
    directed_rows.push_back(r);
  endtask

  // a well-formed string: a few runs of random bytes, end flag on the last byte
  task automatic send_string();
    int runs, len, pick;
    logic [ByteW-1:0] b;
    runs = $urandom_range(1, 6);
    for (int r = 0; r < runs; r++) begin
      pick = $urandom_range(0, 7);
      b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : ByteW'($urandom());
      // mostly short runs, sometimes long enough to pass the cap once or twice
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 19) : $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        send_item(b, (r == runs - 1) && (i == len - 1), -1, '0, '0);
      end
    end
  endtask

  // noise: bytes from a two-letter alphabet with the end flag set at random
  task automatic send_noise();
    int len;
    logic [ByteW-1:0] a0, a1;
    a0 = ByteW'($urandom());
    a1 = ByteW'($urandom());
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      send_item($urandom_range(0, 1) ? a1 : a0, $urandom_range(0, 5) == 0, -1, '0, '0);
    end
  endtask

  // result side: random stall before each output transaction
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready = 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // main sequence
  initial begin
    int strings;
    bit paused;
    strings = 0;
    paused  = 1'b0;
    in_if.valid         = 1'b0;
    in_if.in_byte       = '0;
    in_if.end_of_string = 1'b0;
    run_byte_q = '0;
    run_len_q  = '0;
    run_live_q = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // single-byte strings straight after reset, at both byte extremes
    add_row(8'h00, 1'b1, 1, pair_of(6'd49, 8'h00, 1'b1), '0);
    add_row(8'hff, 1'b1, 1, pair_of(6'd49, 8'hff, 1'b1), '0);
    // nine equal bytes fill the run to the cap without any output
    for (int i = 0; i < 9; i++) add_row(8'h55, 1'b0, 0, '0, '0);
    // the tenth closes a full run and opens a new one
    add_row(8'h55, 1'b0, 1, pair_of(6'd57, 8'h55, 1'b0), '0);
    add_row(8'h55, 1'b1, 1, pair_of(6'd50, 8'h55, 1'b1), '0);
    // byte change together with end of string gives two pairs at once
    add_row(8'h3c, 1'b0, 0, '0, '0);
    add_row(8'hc3, 1'b1, 2, pair_of(6'd49, 8'h3c, 1'b0), pair_of(6'd49, 8'hc3, 1'b1));
    add_row(8'h80, 1'b0, 0, '0, '0);
    add_row(8'h80, 1'b0, 0, '0, '0);
    add_row(8'h01, 1'b0, 1, pair_of(6'd50, 8'h80, 1'b0), '0);
    add_row(8'h01, 1'b1, 1, pair_of(6'd50, 8'h01, 1'b1), '0);
    // adjacent bytes one apart, left to the predictor
    add_row(8'h7f, 1'b0, -1, '0, '0);
    add_row(8'h7e, 1'b0, -1, '0, '0);
    add_row(8'h7e, 1'b1, -1, '0, '0);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].data, directed_rows[i].eos, directed_rows[i].n,
                directed_rows[i].p0, directed_rows[i].p1);
    end

    while (items_sent < 720) begin
      // two stretches with both channels running flat out
      no_idle = (strings >= 10 && strings < 20) || (strings >= 45 && strings < 55);
      if ($urandom_range(0, 99) < 85) begin
        send_string();
      end else begin
        send_noise();
      end
      strings++;
      // once, midway: hold the input back until every pending pair has drained
      if (!paused && items_sent >= 360) begin
        in_if.valid = 1'b0;
        while (expected_pairs.size() != 0) @(posedge clk);
        @(negedge clk);
        paused = 1'b1;
      end
    end
    // close whatever run noise may have left open
    no_idle = 1'b0;
    send_item(8'ha5, 1'b1, -1, '0, '0);
    in_if.valid = 1'b0;

    while (expected_pairs.size() != 0) @(posedge clk);
    // keep the clock running so any stray pair would still be caught
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
